/* src/taoq_pkg.sv */
// ----------------------------------------------------------------------------
// taoq_pkg
// Shared types and constants for the two-class age-ordered queue.
// ----------------------------------------------------------------------------
package taoq_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_WIDTH = 16;
    localparam int FIELD_TAG_W = 16;

    localparam logic CLASS_DOG = 1'b0;
    localparam logic CLASS_CAT = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP_ANY = 2'd1,
        CMD_POP_DOG = 2'd2,
        CMD_POP_CAT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                   command;
        logic [FIELD_TAG_W-1:0] item_tag;
        logic                   item_class;
    } item_t;

    typedef struct packed {
        status_t                status;
        logic [FIELD_TAG_W-1:0] removed_tag;
        logic                   removed_class;
    } result_t;

    typedef struct packed {
        logic [TAG_WIDTH-1:0] tag;
        logic                 cls;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   any;
        logic   want;
        entry_t entry;
    } cell_ctrl_t;

endpackage

/* src/two_class_age_ordered_queue.sv */
// ----------------------------------------------------------------------------
// two_class_age_ordered_queue
// Arrival-ordered queue of tagged entries with pop-oldest-any and
// pop-oldest-of-class commands, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a command beat on item with start high; it is taken when busy is
//   low. busy stays low, so a command can be issued every cycle.
//   Each command gives one result beat on result, marked by done, in the
//   cycle after the command is taken (throughput 1 per cycle).
//   The cells compare classes and pick the oldest match through a ripple
//   along the row, then close up in the same cycle; that ripple across all
//   DEPTH cells sets the cycle time.
//   A push into a full queue returns status full; a pop with no matching
//   entry returns status none; removed fields are zero unless a pop is ok.
//   The receiver cannot stall: done is high for one cycle per result.
//   Reset empties the queue at once and clears done; no clearing pass.
// ----------------------------------------------------------------------------
module two_class_age_ordered_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  taoq_pkg::item_t   item,
    output logic              done,
    output taoq_pkg::result_t result
);

    localparam int DEPTH = taoq_pkg::DEPTH;

    taoq_pkg::cell_ctrl_t ctrl;
    logic                 valid_w [DEPTH];
    taoq_pkg::entry_t     entry_w [DEPTH];
    logic                 taken_w [DEPTH+1];
    taoq_pkg::entry_t     sel_w   [DEPTH+1];

    logic                 done_reg;
    taoq_pkg::result_t    result_reg;
    taoq_pkg::result_t    result_next;

    assign busy = 1'b0;

    always_comb
    begin
        ctrl.push      = start && (item.command == taoq_pkg::CMD_PUSH);
        ctrl.pop       = start && (item.command != taoq_pkg::CMD_PUSH);
        ctrl.any       = (item.command == taoq_pkg::CMD_POP_ANY);
        ctrl.want      = (item.command == taoq_pkg::CMD_POP_CAT) ?
                         taoq_pkg::CLASS_CAT : taoq_pkg::CLASS_DOG;
        ctrl.entry.tag = taoq_pkg::TAG_WIDTH'(item.item_tag);
        ctrl.entry.cls = item.item_class;
    end

    assign taken_w[0] = 1'b0;
    assign sel_w[0]   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             prev_valid;
        logic             next_valid;
        taoq_pkg::entry_t next_entry;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = valid_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_valid = 1'b0;
            assign next_entry = '0;
        end
        else
        begin : g_link
            assign next_valid = valid_w[i+1];
            assign next_entry = entry_w[i+1];
        end

        taoq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_valid),
            .taken_in   (taken_w[i]),
            .sel_in     (sel_w[i]),
            .next_valid (next_valid),
            .next_entry (next_entry),
            .valid      (valid_w[i]),
            .entry      (entry_w[i]),
            .taken_out  (taken_w[i+1]),
            .sel_out    (sel_w[i+1])
        );
    end

    always_comb
    begin
        result_next = '0;
        if (item.command == taoq_pkg::CMD_PUSH)
        begin
            result_next.status = valid_w[DEPTH-1] ? taoq_pkg::ST_FULL : taoq_pkg::ST_OK;
        end
        else if (taken_w[DEPTH])
        begin
            result_next.status        = taoq_pkg::ST_OK;
            result_next.removed_tag   = taoq_pkg::FIELD_TAG_W'(sel_w[DEPTH].tag);
            result_next.removed_class = sel_w[DEPTH].cls;
        end
        else
        begin
            result_next.status = taoq_pkg::ST_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/taoq_cell.sv */
// ----------------------------------------------------------------------------
// taoq_cell
// One queue slot: holds an entry, flags a class match, and closes up from
// its younger neighbor when an older or same-position entry is removed.
// ----------------------------------------------------------------------------
module taoq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  taoq_pkg::cell_ctrl_t ctrl,
    input  logic                prev_valid,
    input  logic                taken_in,
    input  taoq_pkg::entry_t    sel_in,
    input  logic                next_valid,
    input  taoq_pkg::entry_t    next_entry,
    output logic                valid,
    output taoq_pkg::entry_t    entry,
    output logic                taken_out,
    output taoq_pkg::entry_t    sel_out
);

    logic             valid_reg;
    logic             valid_next;
    taoq_pkg::entry_t entry_reg;
    taoq_pkg::entry_t entry_next;
    logic             match;
    logic             hit;
    logic             slot;

    always_comb
    begin
        match     = valid_reg & (ctrl.any | (entry_reg.cls == ctrl.want));
        hit       = match & ~taken_in;
        taken_out = taken_in | match;
        sel_out   = hit ? entry_reg : sel_in;
        slot      = ~valid_reg & prev_valid;

        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.push && slot)
        begin
            valid_next = 1'b1;
            entry_next = ctrl.entry;
        end
        else if (ctrl.pop && taken_out)
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

/* src/taoq_checker.sv */
// ----------------------------------------------------------------------------
// taoq_checker
// Port-level checks for the two-class age-ordered queue.
// ----------------------------------------------------------------------------
module taoq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input taoq_pkg::item_t   item,
    input logic              done,
    input taoq_pkg::result_t result
);

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("taken command gave no result");

    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without a command");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != taoq_pkg::ST_OK) |->
            (result.removed_tag == '0 && result.removed_class == 1'b0))
        else $error("removed fields not zero on failed command");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == taoq_pkg::ST_FULL) |->
            $past(item.command == taoq_pkg::CMD_PUSH))
        else $error("full status on a pop");

    a_push_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(item.command == taoq_pkg::CMD_PUSH)) |->
            (result.status != taoq_pkg::ST_NONE && result.removed_tag == '0))
        else $error("bad push result");

endmodule

bind two_class_age_ordered_queue taoq_checker u_taoq_checker (.*);
